@@ rtl/complex_scalar_alu_macros.svh @@
// Assertion macros used by the complex scalar ALU top level
`ifndef COMPLEX_SCALAR_ALU_MACROS_SVH
`define COMPLEX_SCALAR_ALU_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/csa_pkg.sv @@
// Types, constants and codes of the complex scalar ALU
package csa_pkg;
	localparam int DATA_W        = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int REM_W         = 3 * DATA_W;

	typedef enum logic [2:0] {
		MODE_ADD   = 3'd0,
		MODE_SUB   = 3'd1,
		MODE_MUL   = 3'd2,
		MODE_DIV   = 3'd3,
		MODE_SCALE = 3'd4,
		MODE_NEG   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [DATA_W-1:0] a_real;
		logic signed [DATA_W-1:0] a_imag;
		logic signed [DATA_W-1:0] b_real;
		logic signed [DATA_W-1:0] b_imag;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_real;
		logic signed [DATA_W-1:0] result_imag;
		status_t                  status;
	} rsp_t;

	// One divider lane: partial remainder, quotient bits so far, overflow, sign
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [DATA_W-1:0] quo;
		logic              ovf;
		logic              neg;
	} lane_t;

	// Item state carried down the divider pipeline
	typedef struct packed {
		logic                     use_div;
		logic                     dz;
		logic [PROD_W-1:0]        den;
		logic signed [PROD_W:0]   dir_re;
		logic signed [PROD_W:0]   dir_im;
		lane_t                    re;
		lane_t                    im;
	} pipe_t;
endpackage

@@ rtl/csa_front.sv @@
// Front end: products, mode select and divider setup (three stages)
module csa_front import csa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld_in,
	input  req_t  req,
	output logic  vld_out,
	output pipe_t pipe
);
	logic v_s1, v_s2;
	logic [2:0] md_s1;
	logic signed [DATA_W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PROD_W-1:0] rr_s1, ii_s1, ri_s1, ir_s1, bb_s1, cc_s1;

	logic use_div_s2, dz_s2, neg_re_s2, neg_im_s2;
	logic [PROD_W-1:0] nre_s2, nim_s2, den_s2;
	logic signed [PROD_W:0] dir_re_s2, dir_im_s2;

	logic signed [PROD_W:0] s_re, s_im, n_re, n_im, a_re_x, a_im_x, b_re_x;
	logic use_div_c, dz_c, neg_re_c, neg_im_c;
	logic [PROD_W-1:0] nre_c, nim_c, den_c;
	logic signed [PROD_W:0] dir_re_c, dir_im_c;
	logic [REM_W-1:0] x_re, x_im, d_top;
	pipe_t p_c;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			vld_out <= 1'b0;
		end else if (adv) begin
			v_s1    <= vld_in;
			v_s2    <= v_s1;
			vld_out <= v_s2;
		end
	end

	// Stage 1: all six products
	always_ff @(posedge clk) begin
		if (adv) begin
			md_s1 <= req.mode;
			ar_s1 <= req.a_real;
			ai_s1 <= req.a_imag;
			br_s1 <= req.b_real;
			bi_s1 <= req.b_imag;
			rr_s1 <= PROD_W'(req.a_real * req.b_real);
			ii_s1 <= PROD_W'(req.a_imag * req.b_imag);
			ri_s1 <= PROD_W'(req.a_real * req.b_imag);
			ir_s1 <= PROD_W'(req.a_imag * req.b_real);
			bb_s1 <= PROD_W'(req.b_real * req.b_real);
			cc_s1 <= PROD_W'(req.b_imag * req.b_imag);
		end
	end

	// Stage 2: direct results, or numerator and denominator magnitudes
	always_comb begin
		a_re_x    = (PROD_W+1)'(ar_s1);
		a_im_x    = (PROD_W+1)'(ai_s1);
		b_re_x    = (PROD_W+1)'(br_s1);
		s_re      = 'sh0;
		s_im      = 'sh0;
		n_re      = 'sh0;
		n_im      = 'sh0;
		use_div_c = 1'b0;
		dz_c      = 1'b0;
		neg_re_c  = 1'b0;
		neg_im_c  = 1'b0;
		den_c     = '0;
		dir_re_c  = 'sh0;
		dir_im_c  = 'sh0;
		case (md_s1)
			MODE_ADD: begin
				dir_re_c = a_re_x + (PROD_W+1)'(br_s1);
				dir_im_c = a_im_x + (PROD_W+1)'(bi_s1);
			end
			MODE_SUB: begin
				dir_re_c = a_re_x - (PROD_W+1)'(br_s1);
				dir_im_c = a_im_x - (PROD_W+1)'(bi_s1);
			end
			MODE_MUL: begin
				s_re     = (PROD_W+1)'(rr_s1) - (PROD_W+1)'(ii_s1);
				s_im     = (PROD_W+1)'(ri_s1) + (PROD_W+1)'(ir_s1);
				dir_re_c = s_re >>> FRAC_BITS;
				dir_im_c = s_im >>> FRAC_BITS;
			end
			MODE_DIV: begin
				use_div_c = 1'b1;
				dz_c      = (br_s1 == '0) && (bi_s1 == '0);
				n_re      = (PROD_W+1)'(rr_s1) + (PROD_W+1)'(ii_s1);
				n_im      = (PROD_W+1)'(ir_s1) - (PROD_W+1)'(ri_s1);
				neg_re_c  = n_re[PROD_W];
				neg_im_c  = n_im[PROD_W];
				den_c     = bb_s1 + cc_s1;
			end
			MODE_SCALE: begin
				use_div_c = 1'b1;
				dz_c      = (br_s1 == '0);
				n_re      = a_re_x;
				n_im      = a_im_x;
				neg_re_c  = ar_s1[DATA_W-1] ^ br_s1[DATA_W-1];
				neg_im_c  = ai_s1[DATA_W-1] ^ br_s1[DATA_W-1];
				den_c     = br_s1[DATA_W-1] ? PROD_W'(-b_re_x) : PROD_W'(b_re_x);
			end
			MODE_NEG: begin
				dir_re_c = -a_re_x;
				dir_im_c = -a_im_x;
			end
			default: begin
				dir_re_c = 'sh0;
				dir_im_c = 'sh0;
			end
		endcase
		nre_c = n_re[PROD_W] ? PROD_W'(-n_re) : PROD_W'(n_re);
		nim_c = n_im[PROD_W] ? PROD_W'(-n_im) : PROD_W'(n_im);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			use_div_s2 <= use_div_c;
			dz_s2      <= dz_c;
			neg_re_s2  <= neg_re_c;
			neg_im_s2  <= neg_im_c;
			nre_s2     <= nre_c;
			nim_s2     <= nim_c;
			den_s2     <= den_c;
			dir_re_s2  <= dir_re_c;
			dir_im_s2  <= dir_im_c;
		end
	end

	// Stage 3: scale the numerators and flag quotients that overflow DATA_W bits
	always_comb begin
		x_re  = REM_W'(nre_s2) << FRAC_BITS;
		x_im  = REM_W'(nim_s2) << FRAC_BITS;
		d_top = {den_s2, {DATA_W{1'b0}}};
		p_c.use_div = use_div_s2;
		p_c.dz      = dz_s2;
		p_c.den     = den_s2;
		p_c.dir_re  = dir_re_s2;
		p_c.dir_im  = dir_im_s2;
		p_c.re.rem  = x_re;
		p_c.re.quo  = '0;
		p_c.re.ovf  = x_re >= d_top;
		p_c.re.neg  = neg_re_s2;
		p_c.im.rem  = x_im;
		p_c.im.quo  = '0;
		p_c.im.ovf  = x_im >= d_top;
		p_c.im.neg  = neg_im_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe <= p_c;
		end
	end
endmodule

@@ rtl/csa_div_stage.sv @@
// One restoring-division stage: resolves one quotient bit on both lanes
module csa_div_stage import csa_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld_in,
	input  pipe_t pipe_in,
	output logic  vld_out,
	output pipe_t pipe_out
);
	logic [REM_W-1:0] cand;
	pipe_t p_c;

	// Trial-subtract the shifted denominator on each lane
	always_comb begin
		cand = REM_W'(pipe_in.den) << BIT;
		p_c  = pipe_in;
		if (pipe_in.re.rem >= cand) begin
			p_c.re.rem      = pipe_in.re.rem - cand;
			p_c.re.quo[BIT] = 1'b1;
		end
		if (pipe_in.im.rem >= cand) begin
			p_c.im.rem      = pipe_in.im.rem - cand;
			p_c.im.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_out <= p_c;
		end
	end
endmodule

@@ rtl/csa_back.sv @@
// Back end: saturation, status and the output register
module csa_back import csa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld_in,
	input  pipe_t pipe,
	output logic  rsp_valid,
	output rsp_t  rsp
);
	localparam logic signed [PROD_W:0] MAX_X = (PROD_W+1)'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [PROD_W:0] MIN_X = -MAX_X - 1;
	localparam logic [DATA_W-1:0] LIM_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] LIM_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	logic [DATA_W-1:0] re_v, im_v, lim_re, lim_im, m_re, m_im;
	logic sat_re, sat_im;
	rsp_t r_c;

	// Narrow each part, clipping at the signed range
	always_comb begin
		lim_re = pipe.re.neg ? LIM_NEG : LIM_POS;
		lim_im = pipe.im.neg ? LIM_NEG : LIM_POS;
		sat_re = 1'b0;
		sat_im = 1'b0;
		m_re   = pipe.re.quo;
		m_im   = pipe.im.quo;
		if (pipe.use_div) begin
			if (pipe.re.ovf || (pipe.re.quo > lim_re)) begin
				m_re   = lim_re;
				sat_re = 1'b1;
			end
			if (pipe.im.ovf || (pipe.im.quo > lim_im)) begin
				m_im   = lim_im;
				sat_im = 1'b1;
			end
			re_v = pipe.re.neg ? -m_re : m_re;
			im_v = pipe.im.neg ? -m_im : m_im;
		end else begin
			re_v = DATA_W'(pipe.dir_re);
			im_v = DATA_W'(pipe.dir_im);
			if (pipe.dir_re > MAX_X) begin
				re_v   = LIM_POS;
				sat_re = 1'b1;
			end else if (pipe.dir_re < MIN_X) begin
				re_v   = LIM_NEG;
				sat_re = 1'b1;
			end
			if (pipe.dir_im > MAX_X) begin
				im_v   = LIM_POS;
				sat_im = 1'b1;
			end else if (pipe.dir_im < MIN_X) begin
				im_v   = LIM_NEG;
				sat_im = 1'b1;
			end
		end
		if (pipe.dz) begin
			r_c.result_real = '0;
			r_c.result_imag = '0;
			r_c.status      = ST_DZ;
		end else begin
			r_c.result_real = re_v;
			r_c.result_imag = im_v;
			r_c.status      = (sat_re || sat_im) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= r_c;
		end
	end
endmodule

@@ rtl/complex_scalar_alu.sv @@
// Top level of the complex scalar ALU: front end, divider chain, output stage
//
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid, req_stall | req_t: mode, a_real, a_imag, b_real, b_imag
//  rsp     | out       | rsp_valid, rsp_stall | rsp_t: result_real, result_imag, status
//
//  One item per cycle in every mode while the output is not stalled; the restoring
//  divider resolves one quotient bit per stage.
//  Reset clears all valid bits; payload registers are not reset.
//  A stalled output freezes the whole pipeline and raises req_stall in the same cycle.
`include "complex_scalar_alu_macros.svh"

module complex_scalar_alu import csa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	logic  adv;
	logic  vld  [DATA_W+1];
	pipe_t pipe [DATA_W+1];

	// Move every stage together unless the output transfer is held
	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;

	csa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (req_valid),
		.req     (req),
		.vld_out (vld[0]),
		.pipe    (pipe[0])
	);

	for (genvar gi = 0; gi < DATA_W; gi++) begin : g_div
		csa_div_stage #(.BIT(DATA_W - 1 - gi)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.vld_in   (vld[gi]),
			.pipe_in  (pipe[gi]),
			.vld_out  (vld[gi+1]),
			.pipe_out (pipe[gi+1])
		);
	end

	csa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_in    (vld[DATA_W]),
		.pipe      (pipe[DATA_W]),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	`CSA_ASSERT_NOW(a_dz_zero, rsp_valid && (rsp.status == ST_DZ), (rsp.result_real == '0) && (rsp.result_imag == '0), "divide by zero result not cleared")
	`CSA_ASSERT_NOW(a_sat_bound, rsp_valid && (rsp.status == ST_SAT), (rsp.result_real == {1'b0, {(DATA_W-1){1'b1}}}) || (rsp.result_real == {1'b1, {(DATA_W-1){1'b0}}}) || (rsp.result_imag == {1'b0, {(DATA_W-1){1'b1}}}) || (rsp.result_imag == {1'b1, {(DATA_W-1){1'b0}}}), "saturated status without a clipped part")
	`CSA_ASSERT_NOW(a_stall_src, req_stall, rsp_valid && rsp_stall, "input held without a held output")
	`CSA_ASSERT_NEXT(a_freeze, req_stall, rsp_valid, "output lost while pipeline frozen")
endmodule

@@ sim/csa_checker.sv @@
// Checker for the complex scalar ALU: watches both channels, predicts and compares
module csa_checker import csa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   errors,
	output int   pending,
	output int   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MAX_POS = (64'sd1 <<< (DATA_W - 1)) - 1;
	localparam longint MIN_NEG = -(64'sd1 <<< (DATA_W - 1));

	rsp_t expected_q[$];

	// Narrow an exact value to the output range, flag clipping
	function automatic logic [DATA_W-1:0] clip(input longint v, inout logic sat);
		if (v > MAX_POS) begin
			sat = 1'b1;
			return MAX_POS[DATA_W-1:0];
		end
		if (v < MIN_NEG) begin
			sat = 1'b1;
			return MIN_NEG[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

	// Quotient n * 2^FRAC / d truncated toward zero; operands stay well inside 64 bits
	function automatic longint quot(input longint n, input longint d);
		longint num;
		longint q;
		num = n * (64'sd1 <<< FRAC_BITS_DEF);
		q = (num < 0 ? -num : num) / (d < 0 ? -d : d);
		return ((num < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic rsp_t compute_result(input req_t r);
		longint ar, ai, br, bi, re, im, den;
		logic sat;
		logic dz;
		rsp_t o;
		ar = r.a_real;
		ai = r.a_imag;
		br = r.b_real;
		bi = r.b_imag;
		re = 0;
		im = 0;
		sat = 1'b0;
		dz = 1'b0;
		case (r.mode)
			MODE_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			MODE_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			MODE_MUL: begin
				re = (ar * br - ai * bi) >>> FRAC_BITS_DEF;
				im = (ar * bi + ai * br) >>> FRAC_BITS_DEF;
			end
			MODE_DIV: begin
				if (br == 0 && bi == 0) begin
					dz = 1'b1;
				end else begin
					den = br * br + bi * bi;
					re = quot(ar * br + ai * bi, den);
					im = quot(ai * br - ar * bi, den);
				end
			end
			MODE_SCALE: begin
				if (br == 0) begin
					dz = 1'b1;
				end else begin
					re = quot(ar, br);
					im = quot(ai, br);
				end
			end
			MODE_NEG: begin
				re = -ar;
				im = -ai;
			end
			default: ;
		endcase
		o.result_real = clip(re, sat);
		o.result_imag = clip(im, sat);
		o.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
		return o;
	endfunction

	// Predict on each request transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			expected_q.delete();
			errors <= 0;
			results_seen <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, rsp);
					errors <= errors + 1;
				end else begin
					want = expected_q.pop_front();
					if (rsp.result_real !== want.result_real ||
						rsp.result_imag !== want.result_imag ||
						rsp.status !== want.status) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, rsp);
						errors <= errors + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_q.push_back(compute_result(req));
			pending <= expected_q.size();
		end
	end
endmodule

@@ sim/tb_top.sv @@
// Testbench top for the complex scalar ALU: stimulus, idling and verdict
module tb_top import csa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int errors, pending, results_seen;
	int items_sent = 0;
	bit hold_rsp = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	complex_scalar_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	csa_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Operand with bias toward edge values
	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return '0;
			3: return 16'(int'($urandom_range(0, 1024)) - 512);
			4: return 16'h0100;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Present one item and hold it until the transfer
	task automatic send(input logic [2:0] m, input logic [DATA_W-1:0] ar,
			input logic [DATA_W-1:0] ai, input logic [DATA_W-1:0] br,
			input logic [DATA_W-1:0] bi, input bit keep);
		req_valid <= 1'b1;
		req <= '{mode: m, a_real: ar, a_imag: ai, b_real: br, b_imag: bi};
		do @(posedge clk); while (req_stall);
		items_sent++;
		if (!keep)
			req_valid <= 1'b0;
	endtask

	task automatic send_random(input bit keep);
		logic [2:0] m;
		m = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		send(m, pick_operand(), pick_operand(), pick_operand(), pick_operand(), keep);
	endtask

	// Receiver: random stalls, or a long hold when asked
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (120) @(posedge clk);
				hold_rsp = 1'b0;
			end
			g = gap_len();
			if (g == 0 || $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				rsp_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
		end
	end

	initial begin
		int g;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every mode, zero divisors, negate of minimum, unused modes
		send(MODE_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
		send(MODE_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040, 0);
		send(MODE_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
		send(MODE_SUB, 16'h1234, 16'h4321, 16'h1234, 16'h0001, 0);
		send(MODE_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0);
		send(MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send(MODE_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000, 0);
		send(MODE_MUL, 16'h0180, 16'hff40, 16'h0200, 16'h0100, 0);
		send(MODE_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 0);
		send(MODE_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 0);
		send(MODE_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100, 0);
		send(MODE_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send(MODE_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h0003, 0);
		send(MODE_SCALE, 16'h0500, 16'hfb00, 16'h0000, 16'h1234, 0);
		send(MODE_SCALE, 16'h8000, 16'h7fff, 16'hffff, 16'h0000, 0);
		send(MODE_SCALE, 16'hfffd, 16'h0003, 16'h0200, 16'hffff, 0);
		send(MODE_SCALE, 16'h8000, 16'h0001, 16'h8000, 16'h0000, 0);
		send(MODE_NEG, 16'h8000, 16'h1234, 16'hffff, 16'hffff, 0);
		send(MODE_NEG, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 0);
		send(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0);
		send(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);

		// Random: back-to-back stretches and gaps
		for (int i = 0; i < 1900; i++) begin
			if (i == 600) begin
				// long receiver hold while requests keep coming
				hold_rsp = 1'b1;
				for (int k = 0; k < 60; k++)
					send_random(k != 59);
			end
			if (i == 1200) begin
				// sender drains before continuing
				req_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			g = gap_len();
			send_random(g == 0);
			if (g != 0)
				repeat (g) @(posedge clk);
		end
		req_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (30) @(posedge clk);
		$display("Sent %0d items in all six modes plus unused codes; %0d results checked,",
			items_sent, results_seen);
		$display("with edge operands, zero divisors, random stalls and a long output hold.");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Timeout
	initial begin
		#4ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

@@ complex_scalar_alu.f @@
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_front.sv
rtl/csa_div_stage.sv
rtl/csa_back.sv
rtl/complex_scalar_alu.sv
sim/csa_checker.sv
sim/tb_top.sv
